// ===== design/pusu_pkg.sv =====
package pusu_pkg;

    // Table geometry.
    localparam int CAPACITY = 64;
    localparam int ID_BITS  = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of the request and response transfers.
    localparam int OP_BITS    = 2;
    localparam int ID_FIELD_W = 16;
    localparam int SLOT_BITS  = 6;
    localparam int COUNT_BITS = 7;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [ID_BITS-1:0] key_t;

    // Request kinds. The unused code behaves as a lookup.
    typedef enum logic [OP_BITS-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

endpackage

// ===== design/pusu_if.sv =====
interface pusu_req_if;
    import pusu_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OP_BITS-1:0]    op;
    logic [ID_FIELD_W-1:0] id;

    modport source (output valid, output op, output id, input ready);
    modport sink   (input valid, input op, input id, output ready);
endinterface

interface pusu_rsp_if;
    import pusu_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [SLOT_BITS-1:0]  slot;
    logic [COUNT_BITS-1:0] count;
    logic                  full_res;

    modport source (output valid, output found, output slot, output count,
                     output full_res, input ready);
    modport sink   (input valid, input found, input slot, input count,
                     input full_res, output ready);
endinterface

// ===== design/pusu_ram.sv =====
module pusu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/packed_unique_id_set_unit.sv =====
// Operation: a lookup or insert scans the table slot by slot, at most the held count of
// slots, and then loads the response register. A remove also moves every slot after the
// hit down by one to close the gap.
// Throughput: one request at a time; the next transfer is taken in the cycle after the
// response register loads, so a new request can start while a response waits.
// Reset: asynchronous, active low; count and control clear, table contents are left as is.
module packed_unique_id_set_unit (
    input  logic        clk,
    input  logic        rst_n,
    pusu_req_if.sink    req,
    pusu_rsp_if.source  rsp
);
    import pusu_pkg::*;

    // The sequencer walks the table one slot per cycle through the RAM read port.
    // ST_SCAN searches slots 0..held-1 through the registered read port: the address
    // of slot i goes out while the data of slot i-1 is compared against the key.
    // ST_SHIFT closes the gap after a remove by reading slot i and writing it
    // back to slot i-1, again overlapped so that one slot moves per cycle.
    // ST_DONE waits for the response register to be free and then loads it.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    state_t                state_reg,     state_next;
    logic [OP_BITS-1:0]    op_reg,        op_next;
    key_t                  key_reg,       key_next;
    cnt_t                  held_reg,      held_next;
    cnt_t                  idx_reg,       idx_next;
    logic                  pend_reg,      pend_next;
    idx_t                  pend_idx_reg,  pend_idx_next;
    logic                  found_reg,     found_next;
    idx_t                  pos_reg,       pos_next;
    logic                  full_reg,      full_next;

    // Response register.
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg, out_found_next;
    logic [SLOT_BITS-1:0]  out_slot_reg,  out_slot_next;
    logic [COUNT_BITS-1:0] out_count_reg, out_count_next;
    logic                  out_full_reg,  out_full_next;

    // Table RAM ports.
    logic ram_we;
    idx_t ram_waddr;
    key_t ram_wdata;
    idx_t ram_raddr;
    key_t ram_rdata;

    idx_t last_idx;
    logic hit;
    logic miss;
    logic issue;

    pusu_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign last_idx = IDX_W'(held_reg - cnt_t'(1));

    // A match is only meaningful when a read was issued in the previous cycle.
    // With an empty table the scan ends at once without reading anything.
    assign hit   = pend_reg && (ram_rdata == key_reg);
    assign miss  = (held_reg == '0) || (pend_reg && !hit && (pend_idx_reg == last_idx));
    assign issue = (idx_reg < held_reg);

    assign req.ready    = (state_reg == ST_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.found    = out_found_reg;
    assign rsp.slot     = out_slot_reg;
    assign rsp.count    = out_count_reg;
    assign rsp.full_res = out_full_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        held_next      = held_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_slot_next  = out_slot_reg;
        out_count_next = out_count_reg;
        out_full_next  = out_full_reg;

        ram_we    = 1'b0;
        ram_waddr = held_reg[IDX_W-1:0];
        ram_wdata = key_reg;
        ram_raddr = idx_reg[IDX_W-1:0];

        // The consumer took the waiting response.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.op;
                    key_next   = ID_BITS'(req.id);
                    idx_next   = '0;
                    found_next = 1'b0;
                    pos_next   = '0;
                    full_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    pos_next   = pend_idx_reg;
                    if (op_reg == OP_REMOVE)
                    begin
                        // Start moving entries from the slot after the hit.
                        idx_next   = cnt_t'(pend_idx_reg) + cnt_t'(1);
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (miss)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        if (held_reg < cnt_t'(CAPACITY))
                        begin
                            // Append at the first free slot.
                            ram_we    = 1'b1;
                            pos_next  = held_reg[IDX_W-1:0];
                            held_next = held_reg + cnt_t'(1);
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IDX_W-1:0];
                    if (idx_reg[IDX_W-1:0] != last_idx)
                    begin
                        idx_next = idx_reg + cnt_t'(1);
                    end
                end
            end

            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_idx_reg - idx_t'(1);
                    ram_wdata = ram_rdata;
                end
                if (issue)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + cnt_t'(1);
                end
                else if (!pend_reg)
                begin
                    held_next  = held_reg - cnt_t'(1);
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    out_slot_next  = SLOT_BITS'(pos_reg);
                    out_count_next = COUNT_BITS'(held_reg);
                    out_full_next  = full_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        idx_reg       <= idx_next;
        pend_idx_reg  <= pend_idx_next;
        found_reg     <= found_next;
        pos_reg       <= pos_next;
        full_reg      <= full_next;
        out_found_reg <= out_found_next;
        out_slot_reg  <= out_slot_next;
        out_count_reg <= out_count_next;
        out_full_reg  <= out_full_next;
    end

`ifndef SYNTHESIS
    // The held count never exceeds the table size.
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= cnt_t'(CAPACITY))
        else $error("held count exceeds capacity");

    // One request changes the held count by at most one.
    a_held_step: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg != $past(held_reg)) |->
            ((held_reg == $past(held_reg) + cnt_t'(1)) ||
             (held_reg + cnt_t'(1) == $past(held_reg))))
        else $error("held count moved by more than one");

    // A refused insert is only reported with a full table.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.full_res) |-> (rsp.count == COUNT_BITS'(CAPACITY)))
        else $error("full flag with a table that is not full");

    // A held id is never refused as full.
    a_found_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.found && rsp.full_res))
        else $error("found and full reported together");
`endif

endmodule
